FILE: hdl/aiti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Interface adapter package
// Shared word types, access modes, register map and interrupt flag masks.
// ----------------------------------------------------------------------------
package aiti_pkg;

    // Access modes carried in each input word.
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Bus register map.
    localparam logic [3:0] REG_PORT_B      = 4'd0;
    localparam logic [3:0] REG_PORT_A      = 4'd1;
    localparam logic [3:0] REG_DIR_B       = 4'd2;
    localparam logic [3:0] REG_DIR_A       = 4'd3;
    localparam logic [3:0] REG_T1_CNT_LO   = 4'd4;
    localparam logic [3:0] REG_T1_CNT_HI   = 4'd5;
    localparam logic [3:0] REG_T1_LATCH_LO = 4'd6;
    localparam logic [3:0] REG_T1_LATCH_HI = 4'd7;
    localparam logic [3:0] REG_T2_CNT_LO   = 4'd8;
    localparam logic [3:0] REG_T2_CNT_HI   = 4'd9;
    localparam logic [3:0] REG_SHIFT       = 4'd10;
    localparam logic [3:0] REG_AUX_CTRL    = 4'd11;
    localparam logic [3:0] REG_PERIPH_CTRL = 4'd12;
    localparam logic [3:0] REG_INT_FLAGS   = 4'd13;
    localparam logic [3:0] REG_INT_ENABLE  = 4'd14;
    localparam logic [3:0] REG_PORT_A_NH   = 4'd15;

    // Interrupt flag masks.
    localparam logic [7:0] FLAG_PORT_B  = 8'h18;
    localparam logic [7:0] FLAG_PORT_A  = 8'h03;
    localparam logic [7:0] FLAG_SHIFT   = 8'h04;
    localparam logic [7:0] FLAG_TIMER2  = 8'h20;
    localparam logic [7:0] FLAG_TIMER1  = 8'h40;
    localparam logic [7:0] FLAG_SUMMARY = 8'h80;
    localparam logic [7:0] FLAG_SOURCES = 8'h7F;

    // Aux control bit that enables free-running timer 1.
    localparam int AUX_T1_RELOAD_BIT = 6;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] port_a_in;
        logic [7:0] port_b_in;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] port_a_out;
        logic [7:0] port_b_out;
    } t_out_word;

endpackage : aiti_pkg
`default_nettype wire

FILE: hdl/aiti_state.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Interface adapter register file
// Holds the adapter state and computes the next state and the result word
// for one access or tick.
// ----------------------------------------------------------------------------
module aiti_state (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire aiti_pkg::t_in_word i_word,
    output aiti_pkg::t_out_word     o_result
);

    logic [7:0]  r_out_a, n_out_a;
    logic [7:0]  r_out_b, n_out_b;
    logic [7:0]  r_in_a, n_in_a;
    logic [7:0]  r_in_b, n_in_b;
    logic [7:0]  r_dir_a, n_dir_a;
    logic [7:0]  r_dir_b, n_dir_b;
    logic [15:0] r_t1_count, n_t1_count;
    logic [7:0]  r_t1_latch_lo, n_t1_latch_lo;
    logic [7:0]  r_t1_latch_hi, n_t1_latch_hi;
    logic [7:0]  r_t2_latch_lo, n_t2_latch_lo;
    logic [15:0] r_t2_count, n_t2_count;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_aux_ctrl, n_aux_ctrl;
    logic [7:0]  r_periph_ctrl, n_periph_ctrl;
    logic [7:0]  r_int_flags, n_int_flags;
    logic [7:0]  r_int_enable, n_int_enable;
    logic        r_t2_done, n_t2_done;

    logic [7:0]  rd_data;
    logic [15:0] t1_dec;
    logic [15:0] t2_dec;
    logic [7:0]  set_mask;

    assign t1_dec   = r_t1_count - 16'd1;
    assign t2_dec   = r_t2_count - 16'd1;
    assign set_mask = i_word.write_data & aiti_pkg::FLAG_SOURCES;

    always_comb begin
        n_out_a       = r_out_a;
        n_out_b       = r_out_b;
        n_in_a        = r_in_a;
        n_in_b        = r_in_b;
        n_dir_a       = r_dir_a;
        n_dir_b       = r_dir_b;
        n_t1_count    = r_t1_count;
        n_t1_latch_lo = r_t1_latch_lo;
        n_t1_latch_hi = r_t1_latch_hi;
        n_t2_latch_lo = r_t2_latch_lo;
        n_t2_count    = r_t2_count;
        n_shift       = r_shift;
        n_aux_ctrl    = r_aux_ctrl;
        n_periph_ctrl = r_periph_ctrl;
        n_int_flags   = r_int_flags;
        n_int_enable  = r_int_enable;
        n_t2_done     = r_t2_done;
        rd_data       = '0;

        if (i_en && i_word.mode == aiti_pkg::MODE_READ) begin
            case (i_word.reg_index)
                aiti_pkg::REG_PORT_B: begin
                    rd_data     = (r_in_b & ~r_dir_b) | (r_out_b & r_dir_b);
                    n_int_flags = r_int_flags & ~aiti_pkg::FLAG_PORT_B;
                end
                aiti_pkg::REG_PORT_A: begin
                    rd_data     = r_in_a & ~r_dir_a;
                    n_int_flags = r_int_flags & ~aiti_pkg::FLAG_PORT_A;
                end
                aiti_pkg::REG_PORT_A_NH: rd_data = r_in_a & ~r_dir_a;
                aiti_pkg::REG_DIR_B:     rd_data = r_dir_b;
                aiti_pkg::REG_DIR_A:     rd_data = r_dir_a;
                aiti_pkg::REG_T1_CNT_LO: begin
                    rd_data     = r_t1_count[7:0];
                    n_int_flags = r_int_flags & ~aiti_pkg::FLAG_TIMER1;
                end
                aiti_pkg::REG_T1_CNT_HI:   rd_data = r_t1_count[15:8];
                aiti_pkg::REG_T1_LATCH_LO: rd_data = r_t1_latch_lo;
                aiti_pkg::REG_T1_LATCH_HI: rd_data = r_t1_latch_hi;
                aiti_pkg::REG_T2_CNT_LO: begin
                    rd_data     = r_t2_count[7:0];
                    n_int_flags = r_int_flags & ~aiti_pkg::FLAG_TIMER2;
                end
                aiti_pkg::REG_T2_CNT_HI: rd_data = r_t2_count[15:8];
                aiti_pkg::REG_SHIFT: begin
                    rd_data     = r_shift;
                    n_int_flags = r_int_flags & ~aiti_pkg::FLAG_SHIFT;
                end
                aiti_pkg::REG_AUX_CTRL:    rd_data = r_aux_ctrl;
                aiti_pkg::REG_PERIPH_CTRL: rd_data = r_periph_ctrl;
                aiti_pkg::REG_INT_FLAGS:   rd_data = r_int_flags;
                aiti_pkg::REG_INT_ENABLE:  rd_data = r_int_enable & aiti_pkg::FLAG_SOURCES;
                default:                   rd_data = '0;
            endcase
        end else if (i_en && i_word.mode == aiti_pkg::MODE_WRITE) begin
            case (i_word.reg_index)
                aiti_pkg::REG_PORT_B: begin
                    n_int_flags = r_int_flags & ~aiti_pkg::FLAG_PORT_B;
                    n_out_b     = i_word.write_data & r_dir_b;
                end
                aiti_pkg::REG_PORT_A: begin
                    n_int_flags = r_int_flags & ~aiti_pkg::FLAG_PORT_A;
                    n_out_a     = i_word.write_data & r_dir_a;
                end
                aiti_pkg::REG_PORT_A_NH: n_out_a = i_word.write_data & r_dir_a;
                aiti_pkg::REG_DIR_B:     n_dir_b = i_word.write_data;
                aiti_pkg::REG_DIR_A:     n_dir_a = i_word.write_data;
                aiti_pkg::REG_T1_CNT_LO,
                aiti_pkg::REG_T1_LATCH_LO: n_t1_latch_lo = i_word.write_data;
                aiti_pkg::REG_T1_CNT_HI: begin
                    n_t1_latch_hi = i_word.write_data;
                    n_t1_count    = {i_word.write_data, r_t1_latch_lo};
                    n_int_flags   = r_int_flags & ~aiti_pkg::FLAG_TIMER1;
                end
                aiti_pkg::REG_T1_LATCH_HI: begin
                    n_t1_latch_hi = i_word.write_data;
                    n_int_flags   = r_int_flags & ~aiti_pkg::FLAG_TIMER1;
                end
                aiti_pkg::REG_T2_CNT_LO: n_t2_latch_lo = i_word.write_data;
                aiti_pkg::REG_T2_CNT_HI: begin
                    n_t2_done   = 1'b0;
                    n_t2_count  = {i_word.write_data, r_t2_latch_lo};
                    n_int_flags = r_int_flags & ~aiti_pkg::FLAG_TIMER2;
                end
                aiti_pkg::REG_SHIFT: begin
                    n_int_flags = r_int_flags & ~aiti_pkg::FLAG_SHIFT;
                    n_shift     = i_word.write_data;
                end
                aiti_pkg::REG_AUX_CTRL:    n_aux_ctrl    = i_word.write_data;
                aiti_pkg::REG_PERIPH_CTRL: n_periph_ctrl = i_word.write_data;
                aiti_pkg::REG_INT_FLAGS: begin
                    if (i_word.write_data[7]) begin
                        n_int_flags = r_int_flags | set_mask;
                    end else begin
                        n_int_flags = r_int_flags & ~set_mask;
                    end
                end
                aiti_pkg::REG_INT_ENABLE: begin
                    if (i_word.write_data[7]) begin
                        n_int_enable = r_int_enable | set_mask;
                    end else begin
                        n_int_enable = r_int_enable & ~set_mask;
                    end
                end
                default: n_int_flags = r_int_flags;
            endcase
        end else if (i_en && i_word.mode == aiti_pkg::MODE_TICK) begin
            n_in_a = i_word.port_a_in;
            n_in_b = i_word.port_b_in;
            // Timer 1 only runs while nonzero; on reaching zero it flags and
            // optionally reloads from its latches.
            if (r_t1_count != 16'd0) begin
                n_t1_count = t1_dec;
                if (t1_dec == 16'd0) begin
                    n_int_flags = n_int_flags | aiti_pkg::FLAG_TIMER1;
                    if (r_aux_ctrl[aiti_pkg::AUX_T1_RELOAD_BIT]) begin
                        n_t1_count = {r_t1_latch_hi, r_t1_latch_lo};
                    end
                end
            end
            // Timer 2 always counts and flags only once until rewritten.
            n_t2_count = t2_dec;
            if (t2_dec == 16'd0 && !r_t2_done) begin
                n_int_flags = n_int_flags | aiti_pkg::FLAG_TIMER2;
                n_t2_done   = 1'b1;
            end
            n_int_flags[7] = |(n_int_flags & r_int_enable & aiti_pkg::FLAG_SOURCES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_a       <= '0;
            r_out_b       <= '0;
            r_in_a        <= '0;
            r_in_b        <= '0;
            r_dir_a       <= '0;
            r_dir_b       <= '0;
            r_t1_count    <= '0;
            r_t1_latch_lo <= '0;
            r_t1_latch_hi <= '0;
            r_t2_latch_lo <= '0;
            r_t2_count    <= '0;
            r_shift       <= '0;
            r_aux_ctrl    <= '0;
            r_periph_ctrl <= '0;
            r_int_flags   <= '0;
            r_int_enable  <= '0;
            r_t2_done     <= 1'b0;
        end else begin
            r_out_a       <= n_out_a;
            r_out_b       <= n_out_b;
            r_in_a        <= n_in_a;
            r_in_b        <= n_in_b;
            r_dir_a       <= n_dir_a;
            r_dir_b       <= n_dir_b;
            r_t1_count    <= n_t1_count;
            r_t1_latch_lo <= n_t1_latch_lo;
            r_t1_latch_hi <= n_t1_latch_hi;
            r_t2_latch_lo <= n_t2_latch_lo;
            r_t2_count    <= n_t2_count;
            r_shift       <= n_shift;
            r_aux_ctrl    <= n_aux_ctrl;
            r_periph_ctrl <= n_periph_ctrl;
            r_int_flags   <= n_int_flags;
            r_int_enable  <= n_int_enable;
            r_t2_done     <= n_t2_done;
        end
    end

    assign o_result.read_data  = rd_data;
    assign o_result.irq        = n_int_flags[7];
    assign o_result.port_a_out = n_out_a;
    assign o_result.port_b_out = n_out_b;

endmodule : aiti_state
`default_nettype wire

FILE: hdl/interface_adapter_timers_interrupts_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Interface adapter with timers and interrupts
// Sixteen-register bus adapter with two ports, two timers, a shift register
// and interrupt flag and enable logic, driven by a word stream.
// ----------------------------------------------------------------------------
// Each input word is a register read, a register write or one timer tick, and
// each one produces exactly one result word carrying the read data (zero for
// anything but a read), the interrupt summary bit and both port output
// registers. Words pass through an input register, the update logic on the
// register file, and a result register. One word is taken every cycle when
// the output side keeps up. The result register decouples the two sides: a
// new word is taken while a finished result waits, and input stall rises
// only when both the input and the result registers are full and the output
// side is stalling. Note that the interrupt summary bit is recomputed only
// by a tick, so it can lag a read or write that changes the flags by one
// tick. Port writes store only the bits whose direction bit is set.
// ----------------------------------------------------------------------------
module interface_adapter_timers_interrupts_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire aiti_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output aiti_pkg::t_out_word      o_out_word
);

    // Input stage holding the next word to be applied to the register file.
    logic                r_in_valid;
    aiti_pkg::t_in_word  r_in_word;
    // Result stage presented on the output channel.
    logic                r_out_valid;
    aiti_pkg::t_out_word r_out_word;

    aiti_pkg::t_out_word step_result;
    logic                advance;
    logic                in_take;

    // The held word is applied when the result register is free or drains now.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    aiti_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_word   (r_in_word),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; the valid bits qualify them.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule : interface_adapter_timers_interrupts_core
`default_nettype wire
